[rtl/ordered_array_table_engine_macros.svh]
// ----------------------------------------------------------------------------
// Ordered array table engine assertion macros
// Shared assertion helpers for the table engine RTL.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_TABLE_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_TABLE_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OATE_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OATE_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define OATE_ASSERT_IMPL(label, clk, rst, prop, msg)
`define OATE_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

[rtl/oate_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered array table engine package
// Operation codes, status codes and cell control types.
// ----------------------------------------------------------------------------
`default_nettype none
package oate_pkg;
   localparam logic [3:0] FN_INSERT  = 4'd0;
   localparam logic [3:0] FN_DELETE  = 4'd1;
   localparam logic [3:0] FN_SEARCH  = 4'd2;
   localparam logic [3:0] FN_UPDATE  = 4'd3;
   localparam logic [3:0] FN_APPEND  = 4'd4;
   localparam logic [3:0] FN_MAX     = 4'd5;
   localparam logic [3:0] FN_MIN     = 4'd6;
   localparam logic [3:0] FN_REVERSE = 4'd7;
   localparam logic [3:0] FN_SORT    = 4'd8;
   localparam logic [3:0] FN_DUMP    = 4'd9;
   localparam logic [3:0] FN_CLEAR   = 4'd10;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_BADPOS   = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   typedef enum logic [3:0] {
      CELL_HOLD  = 4'b0001,
      CELL_LOAD  = 4'b0010,
      CELL_SHIFT = 4'b0100,
      CELL_SWAP  = 4'b1000
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [31:0] value;
   } cell_ctl_type;
endpackage
`default_nettype wire

[rtl/oate_cell.sv]
// ----------------------------------------------------------------------------
// Ordered array table engine cell
// Holds one entry; loads, shifts from a neighbor, or does a sort or reverse exchange.
// ----------------------------------------------------------------------------
`default_nettype none
module oate_cell (
   input  wire logic                  clock,
   input  wire oate_pkg::cell_ctl_type ctl,
   input  wire logic                  load_sel,
   input  wire logic                  shift_en,
   input  wire logic [31:0]           shift_value,
   input  wire logic                  swap_en,
   input  wire logic                  swap_upper,
   input  wire logic                  swap_force,
   input  wire logic [31:0]           partner_value,
   output logic [31:0]                entry_value
);
   import oate_pkg::*;
   logic [31:0] entry_ff;
   logic [31:0] entry_in;
   logic        gt;

   assign gt = swap_upper ? ($signed(partner_value) > $signed(entry_ff))
                          : ($signed(entry_ff) > $signed(partner_value));

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_LOAD:  if (load_sel) entry_in = ctl.value;
         CELL_SHIFT: begin
            if (load_sel) entry_in = ctl.value;
            else if (shift_en) entry_in = shift_value;
         end
         CELL_SWAP:  if (swap_en && (gt || swap_force)) entry_in = partner_value;
         default:    entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;
endmodule
`default_nettype wire

[rtl/ordered_array_table_engine.sv]
// Insert, delete, update, append, clear and every error give their word in the cycle after
// the request is taken. Search, max and min walk the chain one entry a cycle, and dump gives
// one word a cycle; the walk pauses while a held response is not taken. Reverse swaps one
// pair a cycle and sort runs DEPTH odd-even rounds; each then gives its word from an output
// state. One item is in work at a time.
// Synchronous active-high reset clears fill count and control and sets capacity to 16.
// ----------------------------------------------------------------------------
// Ordered array table engine
// Packed signed array in a row of cells with one sequencer for all operations.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ordered_array_table_engine_macros.svh"
module ordered_array_table_engine #(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [4:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_func,
   input  wire logic [4:0]  req_position,
   input  wire logic signed [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_index,
   output logic signed [31:0] rsp_result_value,
   output logic             rsp_last
);
   import oate_pkg::*;
   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_WALK = 5'b00010,
      S_SORT = 5'b00100,
      S_REV  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  cap_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic [3:0]  func_ff;
   logic [31:0] val_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] lo_ff, hi_ff;
   logic        odd_ff;
   logic [31:0] best_ff, best_in;
   logic        found_ff, found_in;
   logic [3:0]  fidx_ff, fidx_in;
   logic        ovalid_ff;
   logic [2:0]  ostat_ff;
   logic [3:0]  oidx_ff;
   logic [31:0] oval_ff;
   logic        olast_ff;
   logic [31:0] ev [DEPTH];
   cell_ctl_type ctl;
   logic [DEPTH-1:0] load_sel, shift_en, shift_up;
   logic [CW-1:0] ecap;
   logic        accept, out_free;
   logic [31:0] cur;
   logic        emit;
   logic [2:0]  e_stat;
   logic [3:0]  e_idx;
   logic [31:0] e_val;
   logic        e_last;

   assign ecap = ({1'b0, cap_ff} > (6'(DEPTH))) ? CW'(DEPTH) : CW'(cap_ff);
   assign out_free = !ovalid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept = req_valid && req_ready;
   assign cur = ev[cnt_ff[IW-1:0] < CW'(DEPTH) ? cnt_ff[IW-1:0] : '0];

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; cnt_in = cnt_ff;
      best_in = best_ff; found_in = found_ff; fidx_in = fidx_ff;
      ctl.op = CELL_HOLD; ctl.value = req_value;
      load_sel = '0; shift_en = '0; shift_up = '0;
      emit = 1'b0; e_stat = ST_OK; e_idx = '0; e_val = '0; e_last = 1'b1;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            emit = 1'b1;
            unique case (req_func)
               FN_INSERT, FN_APPEND: begin
                  if (fill_ff >= ecap || fill_ff >= CW'(DEPTH)) e_stat = ST_FULL;
                  else if (req_func == FN_INSERT && (req_position > 5'(fill_ff)))
                     e_stat = ST_BADPOS;
                  else begin
                     ctl.op = CELL_SHIFT;
                     for (int i = 0; i < DEPTH; i++) begin
                        if (req_func == FN_INSERT && 5'(i) > req_position &&
                            CW'(i) <= fill_ff) begin
                           shift_en[i] = 1'b1; shift_up[i] = 1'b1;
                        end
                        if ((req_func == FN_INSERT && 5'(i) == req_position) ||
                            (req_func == FN_APPEND && CW'(i) == fill_ff))
                           load_sel[i] = 1'b1;
                     end
                     fill_in = fill_ff + 1'b1;
                  end
               end
               FN_DELETE: begin
                  if (fill_ff == '0) e_stat = ST_EMPTY;
                  else if (req_position >= 5'(fill_ff)) e_stat = ST_BADPOS;
                  else begin
                     ctl.op = CELL_SHIFT;
                     for (int i = 0; i < DEPTH; i++)
                        if (5'(i) >= req_position && CW'(i + 1) < fill_ff)
                           shift_en[i] = 1'b1;
                     fill_in = fill_ff - 1'b1;
                  end
               end
               FN_UPDATE: begin
                  if (req_position >= 5'(fill_ff)) e_stat = ST_BADPOS;
                  else begin
                     ctl.op = CELL_LOAD;
                     for (int i = 0; i < DEPTH; i++)
                        load_sel[i] = (5'(i) == req_position);
                  end
               end
               FN_SEARCH, FN_MAX, FN_MIN, FN_DUMP: begin
                  if (fill_ff == '0) begin
                     e_stat = (req_func == FN_SEARCH) ? ST_NOTFOUND : ST_EMPTY;
                  end else begin
                     emit = 1'b0; state_in = S_WALK; cnt_in = '0;
                     found_in = 1'b0; best_in = ev[0];
                  end
               end
               FN_REVERSE: if (fill_ff > CW'(1)) begin
                  emit = 1'b0; state_in = S_REV;
               end
               FN_SORT: if (fill_ff > CW'(1)) begin
                  emit = 1'b0; state_in = S_SORT; cnt_in = '0;
               end
               FN_CLEAR: fill_in = '0;
               default: ;
            endcase
         end
         S_WALK: if (out_free) begin
            unique case (func_ff)
               FN_DUMP: begin
                  emit = 1'b1; e_idx = 4'(cnt_ff); e_val = cur;
                  e_last = (cnt_ff + 1'b1 == fill_ff);
               end
               FN_SEARCH: if (!found_ff && cur == val_ff) begin
                  found_in = 1'b1; fidx_in = 4'(cnt_ff);
               end
               FN_MAX: if ($signed(cur) > $signed(best_ff)) best_in = cur;
               default: if ($signed(cur) < $signed(best_ff)) best_in = cur;
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff + 1'b1 == fill_ff) state_in = (func_ff == FN_DUMP) ? S_IDLE : S_OUT;
         end
         S_REV: begin
            ctl.op = CELL_SWAP;
            if (lo_ff < hi_ff) begin
               load_sel[lo_ff] = 1'b1; load_sel[hi_ff] = 1'b1;
            end else state_in = S_OUT;
         end
         S_SORT: begin
            ctl.op = CELL_SWAP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DEPTH - 1)) state_in = S_OUT;
         end
         S_OUT: if (out_free) begin
            emit = 1'b1; state_in = S_IDLE;
            if (func_ff == FN_SEARCH) begin
               e_stat = found_ff ? ST_OK : ST_NOTFOUND;
               e_idx = found_ff ? fidx_ff : 4'd0;
            end else if (func_ff == FN_MAX || func_ff == FN_MIN) e_val = best_ff;
         end
         default: state_in = S_IDLE;
      endcase
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic        sw_en, sw_up;
      logic [31:0] partner, shv;
      if (g == 0) begin : g_first
         assign shv = ev[1];
      end else if (g == DEPTH - 1) begin : g_lastc
         assign shv = ev[g-1];
      end else begin : g_mid
         assign shv = shift_up[g] ? ev[g-1] : ev[g+1];
      end
      always_comb begin
         sw_en = 1'b0; sw_up = 1'b0; partner = ev[g];
         if (state_ff == S_REV) begin
            sw_en = load_sel[g]; sw_up = 1'b0;
            partner = (g == int'(lo_ff)) ? ev[hi_ff] : ev[lo_ff];
         end else if (((g % 2) == 1) == odd_ff) begin
            if (g + 1 < DEPTH && CW'(g + 1) < fill_ff) begin
               sw_en = 1'b1; sw_up = 1'b0; partner = ev[(g + 1) % DEPTH];
            end
         end else if (g > 0 && CW'(g) < fill_ff) begin
            sw_en = 1'b1; sw_up = 1'b1; partner = ev[(g + DEPTH - 1) % DEPTH];
         end
      end
      oate_cell u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .load_sel     (load_sel[g]),
         .shift_en     (shift_en[g]),
         .shift_value  (shv),
         .swap_en      (sw_en && (state_ff == S_REV || state_ff == S_SORT)),
         .swap_upper   (state_ff == S_REV ? 1'b1 : sw_up),
         .swap_force   (state_ff == S_REV),
         .partner_value(partner),
         .entry_value  (ev[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cap_ff <= 5'd16; fill_ff <= '0; ovalid_ff <= 1'b0;
         odd_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fill_ff <= fill_in;
         if (csr_we) cap_ff <= csr_wdata;
         if (emit) ovalid_ff <= 1'b1;
         else if (rsp_ready) ovalid_ff <= 1'b0;
         odd_ff <= (state_ff == S_SORT) ? !odd_ff : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in; best_ff <= best_in; found_ff <= found_in; fidx_ff <= fidx_in;
      if (accept) begin
         func_ff <= req_func; val_ff <= req_value;
         lo_ff <= '0; hi_ff <= IW'(fill_ff - 1'b1);
      end else if (state_ff == S_REV) begin
         lo_ff <= lo_ff + 1'b1; hi_ff <= hi_ff - 1'b1;
      end
      if (emit) begin
         ostat_ff <= e_stat; oidx_ff <= e_idx; oval_ff <= e_val; olast_ff <= e_last;
      end
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_status = ostat_ff;
   assign rsp_index = oidx_ff;
   assign rsp_result_value = oval_ff;
   assign rsp_last = olast_ff;

   `OATE_ASSERT_NEVER(a_fill_depth, clock, reset, fill_ff > CW'(DEPTH), "fill above depth")
   `OATE_ASSERT_IMPL(a_hold_out, clock, reset,
      (rsp_valid && !rsp_ready) |=> $stable(oval_ff), "result changed while stalled")
   `OATE_ASSERT_IMPL(a_busy, clock, reset, (state_ff != S_IDLE) |-> !req_ready,
      "ready while busy")
   `OATE_ASSERT_IMPL(a_fill_step, clock, reset, (state_ff != S_IDLE) |=> $stable(fill_ff),
      "fill changed mid operation")
endmodule
`default_nettype wire
